[sv/mcprd_pkg.sv]
// Shared types and constants for the multi-channel pulse relay driver.
// No dependencies; every other file of the block uses it.
package mcprd_pkg;

   localparam int CHANNELS   = 4;
   localparam int MAX_CH     = 8;
   localparam int KIND_W     = 3;
   localparam int CHAN_W     = 3;
   localparam int DELAY_W    = 32;

   typedef enum logic [KIND_W-1:0] {
      KIND_ON       = 3'd0,
      KIND_OFF      = 3'd1,
      KIND_TOGGLE   = 3'd2,
      KIND_PULSE    = 3'd3,
      KIND_SET_MASK = 3'd4,
      KIND_ALL_ON   = 3'd5,
      KIND_ALL_OFF  = 3'd6,
      KIND_TICK     = 3'd7
   } kind_type;

   typedef struct packed {
      logic               load;
      kind_type           kind;
      logic               hit;
      logic               mask_bit;
      logic [DELAY_W-1:0] delay;
   } chan_cmd_type;

endpackage

[sv/mcprd_if.sv]
// Valid/ready channel interfaces for command and result transactions.
// Depends on mcprd_pkg for field widths.
interface mcprd_req_if;
   logic                         valid;
   logic                         ready;
   logic [mcprd_pkg::KIND_W-1:0] kind;
   logic [mcprd_pkg::CHAN_W-1:0] channel;
   logic [mcprd_pkg::MAX_CH-1:0] bit_mask;
   logic [mcprd_pkg::DELAY_W-1:0] pulse_delay;

   modport source (output valid, kind, channel, bit_mask, pulse_delay, input ready);
   modport sink   (input valid, kind, channel, bit_mask, pulse_delay, output ready);
endinterface

interface mcprd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mcprd_pkg::MAX_CH-1:0] relay_mask;
   logic [mcprd_pkg::MAX_CH-1:0] pin_levels;

   modport source (output valid, relay_mask, pin_levels, input ready);
   modport sink   (input valid, relay_mask, pin_levels, output ready);
endinterface

[sv/mcprd_chan.sv]
// One relay channel: on flag, elapsed-tick counter and auto-off delay.
// Depends on mcprd_pkg for the command struct and kind codes.
module mcprd_chan (
   input  logic                    clock,
   input  logic                    reset,
   input  mcprd_pkg::chan_cmd_type cmd,
   output logic                    on_next
);

   logic                          on_ff, on_in;
   logic [mcprd_pkg::DELAY_W-1:0] elapsed_ff, elapsed_in;
   logic [mcprd_pkg::DELAY_W-1:0] delay_ff, delay_in;
   logic [mcprd_pkg::DELAY_W-1:0] elapsed_inc;

   assign elapsed_inc = elapsed_ff + 1'b1;

   always_comb begin
      on_in      = on_ff;
      elapsed_in = elapsed_ff;
      delay_in   = delay_ff;
      if (cmd.load) begin
         case (cmd.kind)
            mcprd_pkg::KIND_ON: begin
               if (cmd.hit) on_in = 1'b1;
            end
            mcprd_pkg::KIND_OFF: begin
               if (cmd.hit) begin
                  on_in      = 1'b0;
                  elapsed_in = '0;
                  delay_in   = '0;
               end
            end
            mcprd_pkg::KIND_TOGGLE: begin
               if (cmd.hit) begin
                  if (on_ff) begin
                     on_in      = 1'b0;
                     elapsed_in = '0;
                     delay_in   = '0;
                  end else begin
                     on_in = 1'b1;
                  end
               end
            end
            mcprd_pkg::KIND_PULSE: begin
               if (cmd.hit) begin
                  on_in      = 1'b1;
                  elapsed_in = '0;
                  delay_in   = cmd.delay;
               end
            end
            mcprd_pkg::KIND_SET_MASK: begin
               if (cmd.mask_bit) begin
                  on_in = 1'b1;
               end else begin
                  on_in      = 1'b0;
                  elapsed_in = '0;
                  delay_in   = '0;
               end
            end
            mcprd_pkg::KIND_ALL_ON: begin
               on_in = 1'b1;
            end
            mcprd_pkg::KIND_ALL_OFF: begin
               on_in      = 1'b0;
               elapsed_in = '0;
               delay_in   = '0;
            end
            mcprd_pkg::KIND_TICK: begin
               if (on_ff && (delay_ff != '0)) begin
                  elapsed_in = elapsed_inc;
                  if (elapsed_inc >= delay_ff) begin
                     on_in      = 1'b0;
                     elapsed_in = '0;
                     delay_in   = '0;
                  end
               end
            end
            default: begin
               on_in = on_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_ff      <= 1'b0;
         elapsed_ff <= '0;
         delay_ff   <= '0;
      end else begin
         on_ff      <= on_in;
         elapsed_ff <= elapsed_in;
         delay_ff   <= delay_in;
      end
   end

   assign on_next = on_in;

endmodule

[sv/multi_channel_pulse_relay_driver_top.sv]
// Multi-channel pulse relay driver, top level.
// Latency: a result is registered and presented in the cycle after its command is accepted.
// Throughput: one transaction per cycle unless a result stalls; the result register is
// the only stage, so a new command is taken whenever it is empty or being drained.
// Reset: synchronous, active high; all relays off, counters and delays zero,
// active level low, no result pending.
module multi_channel_pulse_relay_driver_top (
   input  logic        clock,
   input  logic        reset,
   mcprd_req_if.sink   req_chan,
   mcprd_rsp_if.source rsp_chan,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   logic                                 active_ff;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [mcprd_pkg::MAX_CH-1:0]         relay_mask_ff, relay_mask_in;
   logic [mcprd_pkg::MAX_CH-1:0]         pin_levels_ff, pin_levels_in;
   logic                                 accept;
   logic [mcprd_pkg::CHANNELS-1:0]       on_next;
   mcprd_pkg::chan_cmd_type              cmd [mcprd_pkg::CHANNELS];

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   for (genvar i = 0; i < mcprd_pkg::CHANNELS; i++) begin : g_chan
      always_comb begin
         cmd[i].load     = accept;
         cmd[i].kind     = mcprd_pkg::kind_type'(req_chan.kind);
         cmd[i].hit      = (req_chan.channel == mcprd_pkg::CHAN_W'(i));
         cmd[i].mask_bit = req_chan.bit_mask[i];
         cmd[i].delay    = req_chan.pulse_delay;
      end

      mcprd_chan u_chan (
         .clock   (clock),
         .reset   (reset),
         .cmd     (cmd[i]),
         .on_next (on_next[i])
      );
   end

   always_comb begin
      relay_mask_in = '0;
      pin_levels_in = '0;
      for (int i = 0; i < mcprd_pkg::CHANNELS; i++) begin
         relay_mask_in[i] = on_next[i];
         pin_levels_in[i] = active_ff ? on_next[i] : !on_next[i];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         active_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) active_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         relay_mask_ff <= relay_mask_in;
         pin_levels_ff <= pin_levels_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.relay_mask = relay_mask_ff;
   assign rsp_chan.pin_levels = pin_levels_ff;

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted transaction produced no result");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("command taken while result stalled");

   a_unused_bits_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((relay_mask_ff >> mcprd_pkg::CHANNELS) == '0 &&
                        (pin_levels_ff >> mcprd_pkg::CHANNELS) == '0))
      else $error("result bits beyond live channels set");

   a_idle_drains: assert property (@(posedge clock) disable iff (reset)
      (!accept && rsp_valid_ff && rsp_chan.ready) |=> !rsp_valid_ff)
      else $error("drained result still valid");

endmodule

[test/tb_multi_channel_pulse_relay_driver_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for the multi-channel pulse relay driver: directed and random
// commands against an in-bench relay model. Depends on mcprd_pkg, mcprd_if and the top.
module tb_multi_channel_pulse_relay_driver_top;

   typedef struct packed {
      logic [mcprd_pkg::MAX_CH-1:0] relay_mask;
      logic [mcprd_pkg::MAX_CH-1:0] pin_levels;
   } relay_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic csr_wr_data = 1'b0;

   mcprd_req_if req_if();
   mcprd_rsp_if rsp_if();

   multi_channel_pulse_relay_driver_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   logic                          relay_on_m [mcprd_pkg::CHANNELS];
   logic [mcprd_pkg::DELAY_W-1:0] tick_count [mcprd_pkg::CHANNELS];
   logic [mcprd_pkg::DELAY_W-1:0] off_after  [mcprd_pkg::CHANNELS];
   logic                          active_high_m = 1'b0;

   relay_state_type pending_states[$];
   int errors = 0;
   int commands_taken = 0;
   int timed_offs = 0;
   int input_stall_cycles = 0;
   bit req_idle_on = 1'b0;
   bit rsp_idle_on = 1'b0;
   int rsp_hold_left = 0;

   initial begin
      for (int i = 0; i < mcprd_pkg::CHANNELS; i++) begin
         relay_on_m[i] = 1'b0;
         tick_count[i] = '0;
         off_after[i]  = '0;
      end
   end

   function automatic void switch_off(input int c);
      relay_on_m[c] = 1'b0;
      tick_count[c] = '0;
      off_after[c]  = '0;
   endfunction

   function automatic relay_state_type apply_command(input mcprd_pkg::kind_type k,
                                                     input logic [mcprd_pkg::CHAN_W-1:0] ch,
                                                     input logic [mcprd_pkg::MAX_CH-1:0] m,
                                                     input logic [mcprd_pkg::DELAY_W-1:0] d);
      relay_state_type s;
      bit in_range;
      in_range = ch < mcprd_pkg::CHANNELS;
      s = '0;
      case (k)
         mcprd_pkg::KIND_ON: begin
            if (in_range) relay_on_m[ch] = 1'b1;
         end
         mcprd_pkg::KIND_OFF: begin
            if (in_range) switch_off(ch);
         end
         mcprd_pkg::KIND_TOGGLE: begin
            if (in_range) begin
               if (relay_on_m[ch]) switch_off(ch);
               else relay_on_m[ch] = 1'b1;
            end
         end
         mcprd_pkg::KIND_PULSE: begin
            if (in_range) begin
               relay_on_m[ch] = 1'b1;
               off_after[ch]  = d;
               tick_count[ch] = '0;
            end
         end
         mcprd_pkg::KIND_SET_MASK: begin
            for (int i = 0; i < mcprd_pkg::CHANNELS; i++) begin
               if (m[i]) relay_on_m[i] = 1'b1;
               else switch_off(i);
            end
         end
         mcprd_pkg::KIND_ALL_ON: begin
            for (int i = 0; i < mcprd_pkg::CHANNELS; i++) relay_on_m[i] = 1'b1;
         end
         mcprd_pkg::KIND_ALL_OFF: begin
            for (int i = 0; i < mcprd_pkg::CHANNELS; i++) switch_off(i);
         end
         default: begin
            for (int i = 0; i < mcprd_pkg::CHANNELS; i++) begin
               if (relay_on_m[i] && off_after[i] != '0) begin
                  tick_count[i] = tick_count[i] + 1'b1;
                  if (tick_count[i] >= off_after[i]) begin
                     switch_off(i);
                     timed_offs++;
                  end
               end
            end
         end
      endcase
      for (int i = 0; i < mcprd_pkg::CHANNELS; i++) begin
         s.relay_mask[i] = relay_on_m[i];
         s.pin_levels[i] = active_high_m ? relay_on_m[i] : ~relay_on_m[i];
      end
      return s;
   endfunction

   always @(posedge clock) begin
      relay_state_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_states.size() == 0) begin
               errors++;
               $display("%0t: unexpected transaction relay_mask %h pin_levels %h",
                        $time, rsp_if.relay_mask, rsp_if.pin_levels);
            end else begin
               want = pending_states.pop_front();
               if (rsp_if.relay_mask !== want.relay_mask) begin
                  errors++;
                  if (errors < 100)
                     $display("%0t: relay_mask expected %h actual %h",
                              $time, want.relay_mask, rsp_if.relay_mask);
               end
               if (rsp_if.pin_levels !== want.pin_levels) begin
                  errors++;
                  if (errors < 100)
                     $display("%0t: pin_levels expected %h actual %h",
                              $time, want.pin_levels, rsp_if.pin_levels);
               end
            end
         end
         if (req_if.valid && !req_if.ready) input_stall_cycles++;
         if (req_if.valid && req_if.ready) begin
            commands_taken++;
            pending_states.push_back(apply_command(mcprd_pkg::kind_type'(req_if.kind),
                                                   req_if.channel, req_if.bit_mask,
                                                   req_if.pulse_delay));
         end
         if (csr_wr_en) active_high_m = csr_wr_data;
      end
   end

   initial begin
      int stall_left;
      stall_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_if.ready = 1'b0;
            rsp_hold_left--;
         end else if (stall_left > 0) begin
            rsp_if.ready = 1'b0;
            stall_left--;
         end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_if.ready = 1'b0;
            stall_left = $urandom_range(0, 8);
         end else begin
            rsp_if.ready = 1'b1;
         end
      end
   end

   task automatic send_cmd(input mcprd_pkg::kind_type k,
                           input logic [mcprd_pkg::CHAN_W-1:0] ch,
                           input logic [mcprd_pkg::MAX_CH-1:0] m,
                           input logic [mcprd_pkg::DELAY_W-1:0] d);
      if (req_idle_on && $urandom_range(0, 4) == 0) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_if.kind        = k;
      req_if.channel     = ch;
      req_if.bit_mask    = m;
      req_if.pulse_delay = d;
      req_if.valid       = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_if.valid = 1'b0;
      while (pending_states.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic set_active_level(input logic level);
      wait_idle();
      csr_wr_en   = 1'b1;
      csr_wr_data = level;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   task automatic test_single_channel();
      send_cmd(mcprd_pkg::KIND_ON,     3'd0, 8'($urandom), $urandom);
      send_cmd(mcprd_pkg::KIND_ON,     3'd3, 8'($urandom), $urandom);
      send_cmd(mcprd_pkg::KIND_OFF,    3'd3, 8'($urandom), $urandom);
      send_cmd(mcprd_pkg::KIND_TOGGLE, 3'd1, 8'($urandom), $urandom);
      send_cmd(mcprd_pkg::KIND_TOGGLE, 3'd1, 8'($urandom), $urandom);
      send_cmd(mcprd_pkg::KIND_ON,     3'd4, 8'($urandom), $urandom);
      send_cmd(mcprd_pkg::KIND_ON,     3'd7, 8'($urandom), $urandom);
      send_cmd(mcprd_pkg::KIND_OFF,    3'd7, 8'($urandom), $urandom);
      send_cmd(mcprd_pkg::KIND_TOGGLE, 3'd5, 8'($urandom), $urandom);
      send_cmd(mcprd_pkg::KIND_PULSE,  3'd6, 8'($urandom), 32'd1);
   endtask

   task automatic test_group_commands();
      send_cmd(mcprd_pkg::KIND_SET_MASK, 3'($urandom), 8'hFF, $urandom);
      send_cmd(mcprd_pkg::KIND_SET_MASK, 3'($urandom), 8'hA5, $urandom);
      send_cmd(mcprd_pkg::KIND_SET_MASK, 3'($urandom), 8'h00, $urandom);
      send_cmd(mcprd_pkg::KIND_ALL_ON,   3'($urandom), 8'($urandom), $urandom);
      send_cmd(mcprd_pkg::KIND_ALL_OFF,  3'($urandom), 8'($urandom), $urandom);
   endtask

   task automatic test_pulse_timing();
      send_cmd(mcprd_pkg::KIND_PULSE,   3'd0, 8'($urandom), 32'd2);
      send_cmd(mcprd_pkg::KIND_ON,      3'd0, 8'($urandom), $urandom);
      send_cmd(mcprd_pkg::KIND_TICK,    3'($urandom), 8'($urandom), $urandom);
      send_cmd(mcprd_pkg::KIND_TICK,    3'($urandom), 8'($urandom), $urandom);
      send_cmd(mcprd_pkg::KIND_PULSE,   3'd1, 8'($urandom), 32'd0);
      send_cmd(mcprd_pkg::KIND_PULSE,   3'd2, 8'($urandom), 32'hFFFF_FFFF);
      send_cmd(mcprd_pkg::KIND_PULSE,   3'd3, 8'($urandom), 32'd1);
      send_cmd(mcprd_pkg::KIND_TICK,    3'($urandom), 8'($urandom), $urandom);
      send_cmd(mcprd_pkg::KIND_TOGGLE,  3'd2, 8'($urandom), $urandom);
      send_cmd(mcprd_pkg::KIND_ALL_OFF, 3'($urandom), 8'($urandom), $urandom);
   endtask

   task automatic test_random_commands(input int count, input bit with_idle);
      mcprd_pkg::kind_type k;
      logic [mcprd_pkg::CHAN_W-1:0] ch;
      logic [mcprd_pkg::DELAY_W-1:0] d;
      int pick;
      for (int n = 0; n < count; n++) begin
         if (n % 64 == 0) begin
            req_idle_on = with_idle && ($urandom_range(0, 3) != 0);
            rsp_idle_on = with_idle && ($urandom_range(0, 3) != 0);
         end
         pick = $urandom_range(0, 99);
         if (pick < 30) k = mcprd_pkg::KIND_TICK;
         else if (pick < 50) k = mcprd_pkg::KIND_PULSE;
         else k = mcprd_pkg::kind_type'($urandom_range(0, 6));
         if ($urandom_range(0, 7) == 0) ch = mcprd_pkg::CHAN_W'($urandom_range(0, 7));
         else ch = mcprd_pkg::CHAN_W'($urandom_range(0, mcprd_pkg::CHANNELS - 1));
         case ($urandom_range(0, 9))
            0: d = '0;
            1: d = $urandom;
            default: d = mcprd_pkg::DELAY_W'($urandom_range(1, 6));
         endcase
         send_cmd(k, ch, 8'($urandom), d);
      end
   endtask

   task automatic test_result_backpressure();
      req_idle_on   = 1'b0;
      rsp_idle_on   = 1'b0;
      rsp_hold_left = 80;
      test_random_commands(40, 1'b0);
   endtask

   initial begin
      req_if.valid       = 1'b0;
      req_if.kind        = '0;
      req_if.channel     = '0;
      req_if.bit_mask    = '0;
      req_if.pulse_delay = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_single_channel();
      test_group_commands();
      test_pulse_timing();
      set_active_level(1'b1);
      test_random_commands(500, 1'b1);
      set_active_level(1'b0);
      test_random_commands(500, 1'b1);
      set_active_level(1'b1);
      test_result_backpressure();
      test_random_commands(500, 1'b0);

      wait_idle();
      repeat (4) @(negedge clock);
      $display("Checked %0d commands of every kind at both active levels, in and out of range.",
               commands_taken);
      $display("%0d timed switch-offs; input held off for %0d cycles by result stalls.",
               timed_offs, input_stall_cycles);
      if (errors == 0 && pending_states.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
